### sv/cmf_pkg.sv
// Shared types and constants for the Catmull-Rom spline evaluator.
// Depends on nothing; the queue, front, back, top level and testbench files import it.
`default_nettype none
package cmf_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COORD_WIDTH    = 32;
	localparam int SAT_BITS       = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int DATA_W         = 32;
	localparam int PT_W           = 3 * DATA_W;
	localparam int IDX_W_MAX      = 12;
	localparam int U_W_MAX        = 25;
	localparam int ACC_W          = 40;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_EVAL   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_FEW,
		KIND_EVAL
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_CALC,
		B_DONE
	} bstate_t;

	typedef struct packed {
		kind_t                kind;
		logic                 status;
		logic                 one_pt;
		logic [IDX_W_MAX-1:0] idx0;
		logic [IDX_W_MAX-1:0] idx1;
		logic [IDX_W_MAX-1:0] idx2;
		logic [IDX_W_MAX-1:0] idx3;
		logic [U_W_MAX-1:0]   u;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

### sv/cmf_in_if.sv
// Input channel of the spline evaluator: valid/ready plus one command item.
// Depends on nothing.
`default_nettype none
interface cmf_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic signed [31:0] eval_t;
	modport source(output valid, cmd, point_x, point_y, point_z, eval_t, input ready);
	modport sink(input valid, cmd, point_x, point_y, point_z, eval_t, output ready);
endinterface
`default_nettype wire

### sv/cmf_out_if.sv
// Output channel of the spline evaluator: valid/ready plus one result item.
// Depends on nothing.
`default_nettype none
interface cmf_out_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] tan_x;
	logic signed [31:0] tan_y;
	logic signed [31:0] tan_z;
	modport source(output valid, status, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
		input ready);
	modport sink(input valid, status, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
		output ready);
endinterface
`default_nettype wire

### sv/cmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module cmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/cmf_queue.sv
// Two-entry descriptor queue between the front and back parts.
// Depends on cmf_pkg.
`default_nettype none
module cmf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cmf_pkg::desc_t   desc_in,
	input  logic             pop,
	output cmf_pkg::desc_t   desc_out,
	output cmf_pkg::q_stat_t stat
);
	import cmf_pkg::*;

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	// status and head of queue
	always_comb begin
		stat.full  = (cnt_q == 2'd2);
		stat.empty = (cnt_q == 2'd0);
		desc_out   = ent_q[rd_ptr_q];
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= desc_in;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### sv/cmf_front.sv
// Front part: accepts items, keeps the point count, writes appended points
// and turns evaluations into segment indices and local t. Depends on cmf_pkg.
`default_nettype none
module cmf_front #(
	parameter int MAX_POINTS = cmf_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = cmf_pkg::FRAC_BITS_DEF,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	cmf_in_if.sink                   req,
	input  logic                     busy,
	input  cmf_pkg::q_stat_t         q_stat,
	output logic                     q_push,
	output cmf_pkg::desc_t           q_desc,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic [cmf_pkg::PT_W-1:0] ram_wdata
);
	import cmf_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int TW = (CW + FRAC_BITS + 1 > 33) ? (CW + FRAC_BITS + 1) : 33;
	localparam int UW = FRAC_BITS + 1;

	logic [CW-1:0]        count_q;
	logic                 full;
	logic                 few;
	logic signed [TW-1:0] t_ext;
	logic signed [TW-1:0] max_t;
	logic signed [TW-1:0] t_c;
	logic [CW-1:0]        seg;
	logic [CW-1:0]        last;
	logic [UW-1:0]        u;
	logic [CW-1:0]        i0;
	logic [CW-1:0]        i2;
	logic [CW-1:0]        i3;

	// clamp t, pick segment and the four point indices
	always_comb begin
		full  = (count_q == CW'(MAX_POINTS));
		few   = (count_q < CW'(2));
		t_ext = {{(TW - 32){req.eval_t[31]}}, req.eval_t};
		max_t = TW'({count_q - CW'(1), {FRAC_BITS{1'b0}}});
		if (t_ext < 0) begin
			t_c = '0;
		end else if (t_ext > max_t) begin
			t_c = max_t;
		end else begin
			t_c = t_ext;
		end
		seg  = t_c[FRAC_BITS +: CW];
		u    = {1'b0, t_c[FRAC_BITS-1:0]};
		last = count_q - CW'(2);
		if (seg >= last) begin
			seg = last;
			if (t_c >= max_t) begin
				u = UW'(1) << FRAC_BITS;
			end
		end
		i2 = seg + CW'(1);
		i0 = (seg != '0) ? seg - CW'(1) : '0;
		i3 = (seg + CW'(2) < count_q) ? seg + CW'(2) : count_q - CW'(1);
	end

	// build the descriptor for the back part
	always_comb begin
		q_desc        = '0;
		q_desc.kind   = KIND_PLAIN;
		q_desc.status = 1'b0;
		case (req.cmd)
			CMD_APPEND: begin
				q_desc.status = full;
			end
			CMD_EVAL: begin
				if (few) begin
					q_desc.kind   = KIND_FEW;
					q_desc.one_pt = (count_q == CW'(1));
				end else begin
					q_desc.kind = KIND_EVAL;
					q_desc.idx0 = IDX_W_MAX'(i0[AW-1:0]);
					q_desc.idx1 = IDX_W_MAX'(seg[AW-1:0]);
					q_desc.idx2 = IDX_W_MAX'(i2[AW-1:0]);
					q_desc.idx3 = IDX_W_MAX'(i3[AW-1:0]);
					q_desc.u    = U_W_MAX'(u);
				end
			end
			default: begin
				q_desc.kind = KIND_PLAIN;
			end
		endcase
	end

	// handshake: hold a clear until the queue is empty and the back part is idle
	always_comb begin
		req.ready = !q_stat.full &&
			!((req.cmd == CMD_CLEAR) && (busy || !q_stat.empty));
		q_push    = req.valid && req.ready;
		ram_we    = q_push && (req.cmd == CMD_APPEND) && !full;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {req.point_z, req.point_y, req.point_x};
	end

	// point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push && (req.cmd == CMD_CLEAR)) begin
			count_q <= '0;
		end else if (ram_we) begin
			count_q <= count_q + CW'(1);
		end
	end
endmodule
`default_nettype wire

### sv/cmf_back.sv
// Back part: reads four control points, runs the Horner steps for position
// and tangent on three lanes, and holds the result item. Depends on cmf_pkg.
`default_nettype none
module cmf_back #(
	parameter int MAX_POINTS = cmf_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = cmf_pkg::FRAC_BITS_DEF,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  cmf_pkg::desc_t           q_desc,
	output logic                     q_pop,
	output logic                     busy,
	output logic [AW-1:0]            ram_raddr,
	input  logic [cmf_pkg::PT_W-1:0] ram_rdata,
	cmf_out_if.source                rsp
);
	import cmf_pkg::*;

	localparam int PW = ACC_W + FRAC_BITS + 2;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] ONE_FX = ACC_W'(64'sd1 <<< FRAC_BITS);

	bstate_t state_q, state_d;
	desc_t   desc_q;
	logic [2:0] rd_cnt_q;
	logic [1:0] step_q;
	logic [PT_W-1:0] p_q [4];
	logic signed [ACC_W-1:0] pacc_q [3];
	logic signed [ACC_W-1:0] tacc_q [3];
	logic out_valid_q;
	logic out_load;
	logic status_q;
	logic signed [DATA_W-1:0] pos_q [3];
	logic signed [DATA_W-1:0] tan_q [3];

	logic signed [ACC_W-1:0] pe [4][3];
	logic signed [ACC_W-1:0] c1 [3];
	logic signed [ACC_W-1:0] c2 [3];
	logic signed [ACC_W-1:0] c3 [3];
	logic signed [ACC_W-1:0] d1 [3];
	logic signed [ACC_W-1:0] d2 [3];
	logic signed [ACC_W-1:0] pnext [3];
	logic signed [ACC_W-1:0] tnext [3];
	logic [FRAC_BITS:0] u;

	// rounded product by local t, half toward plus infinity
	function automatic logic signed [ACC_W-1:0] mul_u(input logic signed [ACC_W-1:0] x,
			input logic [FRAC_BITS:0] uu);
		logic signed [PW-1:0] prod;
		prod = PW'(x) * PW'($signed({1'b0, uu}));
		prod = prod + (PW'(1) <<< (FRAC_BITS - 1));
		return ACC_W'(prod >>> FRAC_BITS);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (r > SAT_HI) begin
			r = SAT_HI;
		end
		if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return DATA_W'(r);
	endfunction

	function automatic logic signed [ACC_W-1:0] halve(input logic signed [ACC_W-1:0] v);
		return (v + ACC_W'(1)) >>> 1;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					state_d = (q_desc.kind == KIND_PLAIN) ? B_DONE : B_READ;
				end
			end
			B_READ: begin
				if (rd_cnt_q == 3'd4) begin
					state_d = (desc_q.kind == KIND_EVAL) ? B_CALC : B_DONE;
				end
			end
			B_CALC: begin
				if (step_q == 2'd2) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_load) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = (state_q == B_IDLE) && q_valid;
		busy     = (state_q != B_IDLE);
		out_load = (state_q == B_DONE) && (!out_valid_q || rsp.ready);
		unique case (rd_cnt_q[1:0])
			2'd0: ram_raddr = desc_q.idx0[AW-1:0];
			2'd1: ram_raddr = desc_q.idx1[AW-1:0];
			2'd2: ram_raddr = desc_q.idx2[AW-1:0];
			default: ram_raddr = desc_q.idx3[AW-1:0];
		endcase
	end

	// coefficients and one Horner step on each lane
	always_comb begin
		u = desc_q.u[FRAC_BITS:0];
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 3; k++) begin
				pe[j][k] = ACC_W'($signed(p_q[j][k*DATA_W +: DATA_W]));
			end
		end
		for (int k = 0; k < 3; k++) begin
			c1[k] = pe[2][k] - pe[0][k];
			c2[k] = (pe[0][k] <<< 1) - ((pe[1][k] <<< 2) + pe[1][k])
				+ (pe[2][k] <<< 2) - pe[3][k];
			c3[k] = -pe[0][k] + ((pe[1][k] <<< 1) + pe[1][k])
				- ((pe[2][k] <<< 1) + pe[2][k]) + pe[3][k];
			d1[k] = (pe[0][k] <<< 2) - ((pe[1][k] <<< 3) + (pe[1][k] <<< 1))
				+ (pe[2][k] <<< 3) - (pe[3][k] <<< 1);
			d2[k] = -((pe[0][k] <<< 1) + pe[0][k]) + ((pe[1][k] <<< 3) + pe[1][k])
				- ((pe[2][k] <<< 3) + pe[2][k]) + ((pe[3][k] <<< 1) + pe[3][k]);
			case (step_q)
				2'd0: begin
					pnext[k] = mul_u(c3[k], u) + c2[k];
					tnext[k] = mul_u(d2[k], u) + d1[k];
				end
				2'd1: begin
					pnext[k] = mul_u(pacc_q[k], u) + c1[k];
					tnext[k] = mul_u(tacc_q[k], u) + c1[k];
				end
				default: begin
					pnext[k] = mul_u(pacc_q[k], u) + (pe[1][k] <<< 1);
					tnext[k] = tacc_q[k];
				end
			endcase
		end
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rd_cnt_q    <= 3'd0;
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= (state_q == B_READ) ? rd_cnt_q + 3'd1 : 3'd0;
			step_q   <= (state_q == B_CALC) ? step_q + 2'd1 : 2'd0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_desc;
		end
		if ((state_q == B_READ) && (rd_cnt_q != 3'd0)) begin
			p_q[rd_cnt_q[1:0] - 2'd1] <= ram_rdata;
		end
		if (state_q == B_CALC) begin
			for (int k = 0; k < 3; k++) begin
				pacc_q[k] <= pnext[k];
				tacc_q[k] <= tnext[k];
			end
		end
		if (out_load) begin
			status_q <= desc_q.status;
			for (int k = 0; k < 3; k++) begin
				case (desc_q.kind)
					KIND_EVAL: begin
						pos_q[k] <= sat(halve(pacc_q[k]));
						tan_q[k] <= sat(halve(tacc_q[k]));
					end
					KIND_FEW: begin
						pos_q[k] <= desc_q.one_pt ? sat(pe[0][k]) : '0;
						tan_q[k] <= (k == 2) ? sat(ONE_FX) : '0;
					end
					default: begin
						pos_q[k] <= '0;
						tan_q[k] <= '0;
					end
				endcase
			end
		end
	end

	// drive the result channel
	assign rsp.valid  = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.pos_x  = pos_q[0];
	assign rsp.pos_y  = pos_q[1];
	assign rsp.pos_z  = pos_q[2];
	assign rsp.tan_x  = tan_q[0];
	assign rsp.tan_y  = tan_q[1];
	assign rsp.tan_z  = tan_q[2];
endmodule
`default_nettype wire

### sv/catmull_rom_spline_evaluator.sv
// Catmull-Rom spline evaluator top level: front, queue, point RAM, back.
// Depends on cmf_pkg, cmf_in_if, cmf_out_if and all cmf_* modules.
//
// Usage: items arrive on req (cmd 0 clear, 1 append point, 2 evaluate at
// eval_t); every item yields exactly one result on rsp, in order. Appends to
// a full store return status 1 and drop the point.
// The front takes one item per cycle into a two-entry queue, unless the queue
// is full or a clear must wait. The back takes one queued item at a time. A
// clear, append or unused code goes from idle straight to the output state.
// An evaluation is taken from the queue, then uses the single read port of
// the point RAM (four addresses plus the registered read data), runs 3 Horner
// steps on three lanes and loads the output register. An evaluation with
// fewer than two points skips the Horner steps.
// A clear waits at the input until the queue is empty and the back is idle.
// When rsp stalls, the result is held; the queue fills and req.ready drops.
// Reset empties the queue and sets the point count to zero; the point RAM
// is not cleared and needs no clearing pass.
`default_nettype none
module catmull_rom_spline_evaluator #(
	parameter int MAX_POINTS = cmf_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = cmf_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cmf_in_if.sink    req,
	cmf_out_if.source rsp
);
	import cmf_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic            q_push;
	logic            q_pop;
	q_stat_t         q_stat;
	desc_t           desc_in;
	desc_t           desc_out;
	logic            busy;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [PT_W-1:0] ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [PT_W-1:0] ram_rdata;

	cmf_front #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .busy(busy), .q_stat(q_stat),
		.q_push(q_push), .q_desc(desc_in), .ram_we(ram_we),
		.ram_waddr(ram_waddr), .ram_wdata(ram_wdata)
	);

	cmf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .desc_in(desc_in),
		.pop(q_pop), .desc_out(desc_out), .stat(q_stat)
	);

	cmf_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	cmf_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(!q_stat.empty), .q_desc(desc_out),
		.q_pop(q_pop), .busy(busy), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
		.rsp(rsp)
	);

`ifndef NO_ASSERTIONS
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.cmd == CMD_CLEAR)) |-> (q_stat.empty && !busy))
		else $error("clear accepted while items in flight");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue pop while empty");
	a_write_on_append: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (req.valid && req.ready && (req.cmd == CMD_APPEND)))
		else $error("point write without accepted append");
`endif
endmodule
`default_nettype wire

### sim/catmull_rom_spline_evaluator_checker.sv
// Checker for the spline evaluator: watches req and rsp, predicts each result.
// Depends on cmf_pkg, cmf_in_if and cmf_out_if.
`timescale 1ns / 1ps
module catmull_rom_spline_evaluator_checker (
	input logic       clk,
	input logic       arst_n,
	cmf_in_if.sink    req,
	cmf_out_if.sink   rsp,
	output int        fail_count,
	output int        pending,
	output int        evals_seen,
	output int        drops_seen
);
	import cmf_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int FB   = FRAC_BITS_DEF;

	typedef struct packed {
		logic               status;
		logic signed [31:0] px, py, pz, tx, ty, tz;
	} spline_res_t;

	longint      pts [NPTS][3];
	int          npts;
	spline_res_t result_q[$];

	function automatic longint fshift(longint x, int s);
		if (x >= 0) return x >>> s;
		return -(((-x) + ((longint'(1) << s) - 1)) >>> s);
	endfunction

	function automatic longint umul(longint x, longint u);
		return fshift(x * u + (longint'(1) << (FB - 1)), FB);
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Add one expected result at the tail of the queue
	function automatic void queue_expected(spline_res_t r);
		result_q.insert(result_q.size(), r);
	endfunction

	// Compute the expected result of one accepted command and update the store
	function automatic spline_res_t predict_spline(logic [1:0] cmd, logic signed [31:0] x,
		logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] t_in);
		spline_res_t r;
		longint one, maxt, t, seg, u, last, p0, p1, p2, p3, c1, c2, c3, d1, d2, acc;
		longint pos[3], tng[3];
		int i0, i1, i2, i3;
		r = '0;
		one = longint'(1) << FB;
		case (cmd)
			CMD_CLEAR: npts = 0;
			CMD_APPEND: begin
				if (npts >= NPTS) r.status = 1'b1;
				else begin
					pts[npts][0] = x; pts[npts][1] = y; pts[npts][2] = z;
					npts++;
				end
			end
			CMD_EVAL: begin
				if (npts < 2) begin
					for (int k = 0; k < 3; k++) begin
						pos[k] = (npts == 1) ? pts[0][k] : 0;
						tng[k] = 0;
					end
					tng[2] = one;
				end else begin
					maxt = longint'(npts - 1) << FB;
					t = t_in;
					if (t < 0) t = 0;
					if (t > maxt) t = maxt;
					seg = t >>> FB;
					u = t & (one - 1);
					last = npts - 2;
					if (seg >= last) begin
						seg = last;
						if (t >= maxt) u = one;
					end
					i1 = seg; i2 = i1 + 1;
					i0 = (i1 > 0) ? i1 - 1 : 0;
					i3 = (i1 + 2 < npts) ? i1 + 2 : npts - 1;
					for (int k = 0; k < 3; k++) begin
						p0 = pts[i0][k]; p1 = pts[i1][k]; p2 = pts[i2][k]; p3 = pts[i3][k];
						c1 = -p0 + p2;
						c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
						c3 = -p0 + 3 * p1 - 3 * p2 + p3;
						d1 = 4 * p0 - 10 * p1 + 8 * p2 - 2 * p3;
						d2 = -3 * p0 + 9 * p1 - 9 * p2 + 3 * p3;
						acc = umul(c3, u) + c2;
						acc = umul(acc, u) + c1;
						acc = umul(acc, u) + 2 * p1;
						pos[k] = fshift(acc + 1, 1);
						acc = umul(d2, u) + d1;
						acc = umul(acc, u) + c1;
						tng[k] = fshift(acc + 1, 1);
					end
				end
				r.px = clip32(pos[0]); r.py = clip32(pos[1]); r.pz = clip32(pos[2]);
				r.tx = clip32(tng[0]); r.ty = clip32(tng[1]); r.tz = clip32(tng[2]);
			end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = result_q.size();

	// Predict on accepted commands, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		spline_res_t e, a;
		if (!arst_n) begin
			npts = 0;
			fail_count <= 0;
			evals_seen <= 0;
			drops_seen <= 0;
			result_q.delete();
		end else begin
			if (req.valid && req.ready) begin
				queue_expected(predict_spline(req.cmd, req.point_x, req.point_y,
					req.point_z, req.eval_t));
				if (req.cmd == CMD_EVAL) evals_seen <= evals_seen + 1;
			end
			if (rsp.valid && rsp.ready) begin
				a = {rsp.status, rsp.pos_x, rsp.pos_y, rsp.pos_z,
					rsp.tan_x, rsp.tan_y, rsp.tan_z};
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, a);
					fail_count <= fail_count + 1;
				end else begin
					e = result_q.pop_front();
					if (e.status) drops_seen <= drops_seen + 1;
					if (e != a) begin
						$display("%0t: mismatch expected st=%0d pos=%0d,%0d,%0d tan=%0d,%0d,%0d",
							$time, e.status, e.px, e.py, e.pz, e.tx, e.ty, e.tz);
						$display("%0t:            actual st=%0d pos=%0d,%0d,%0d tan=%0d,%0d,%0d",
							$time, a.status, a.px, a.py, a.pz, a.tx, a.ty, a.tz);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

### sim/catmull_rom_spline_evaluator_tb.sv
// Testbench top for the spline evaluator: clock, reset, stimulus and verdict.
// Depends on cmf_pkg, both channel interfaces, the block and its checker.
`timescale 1ns / 1ps
module catmull_rom_spline_evaluator_tb;
	import cmf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fails, pending, evals, drops;
	int   cycles = 0;
	bit   calm = 1'b0;

	cmf_in_if  req();
	cmf_out_if rsp();

	catmull_rom_spline_evaluator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	catmull_rom_spline_evaluator_checker chk (.clk(clk), .arst_n(arst_n), .req(req),
		.rsp(rsp), .fail_count(fails), .pending(pending), .evals_seen(evals),
		.drops_seen(drops));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0; req.cmd = CMD_CLEAR;
		req.point_x = '0; req.point_y = '0; req.point_z = '0; req.eval_t = '0;
		rsp.ready = 1'b0;
	end

	// Stall the result side about one cycle in ten, except in calm stretches
	always @(posedge clk) begin
		if (arst_n) rsp.ready <= calm || ($urandom_range(99) >= 10);
	end

	// End the run if it stalls
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("FAIL catmull_rom_spline_evaluator");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(65535) << 8;
			3: return {{12{1'b0}}, 20'($urandom)} - 32'h00080000;
			default: return $urandom;
		endcase
	endfunction

	// Offer one item and hold it until accepted; idle cycles drop valid
	task automatic send_item(cmd_t c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] t);
		while (!calm && $urandom_range(99) < 10) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1; req.cmd <= c;
		req.point_x <= x; req.point_y <= y; req.point_z <= z; req.eval_t <= t;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic eval_at(logic [31:0] t);
		send_item(CMD_EVAL, rand_word(), rand_word(), rand_word(), t);
	endtask

	initial begin
		int n, cnt;
		logic [31:0] t;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty, one point, two points, ends of t, overflow of the store
		eval_at(32'h0);
		send_item(CMD_APPEND, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
		eval_at(32'h80000000);
		send_item(CMD_APPEND, 32'h80000000, 32'h7fffffff, 32'hffff0000, 0);
		eval_at(32'h80000000);
		eval_at(32'h7fffffff);
		eval_at(32'h00008000);
		eval_at(32'h00010000);
		send_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		eval_at(32'h00020000);
		for (int i = 0; i < 66; i++)
			send_item(CMD_APPEND, $urandom, $urandom, $urandom, $urandom);
		eval_at(32'h003f0000);
		eval_at(32'h003effff);
		eval_at(32'h00000001);
		send_item(CMD_CLEAR, 0, 0, 0, 0);

		// Random: build stores of random size, then evaluate across them
		n = 0;
		while (n < 1650) begin
			calm = (n >= 700 && n < 900);
			cnt = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(8);
			for (int i = 0; i < cnt; i++) begin
				send_item(CMD_APPEND, rand_word(), rand_word(), rand_word(), $urandom);
				n++;
			end
			repeat ($urandom_range(10, 2)) begin
				case ($urandom_range(7))
					0: t = $urandom;
					1: t = 32'h80000000 | $urandom;
					2: t = {16'($urandom_range(cnt)), 16'h0000};
					default: t = $urandom_range(cnt << 16);
				endcase
				if ($urandom_range(19) == 0)
					send_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
				else eval_at(t);
				n++;
			end
			send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
			n++;
		end
		req.valid <= 1'b0;

		// Drain
		calm = 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("Covered %0d evaluations and %0d dropped appends over random stores.",
			evals, drops);
		if (fails == 0 && pending == 0) $display("PASS catmull_rom_spline_evaluator");
		else $display("FAIL catmull_rom_spline_evaluator");
		$finish;
	end
endmodule

### catmull_rom_spline_evaluator.f
sv/cmf_pkg.sv
sv/cmf_in_if.sv
sv/cmf_out_if.sv
sv/cmf_ram.sv
sv/cmf_queue.sv
sv/cmf_front.sv
sv/cmf_back.sv
sv/catmull_rom_spline_evaluator.sv
sim/catmull_rom_spline_evaluator_checker.sv
sim/catmull_rom_spline_evaluator_tb.sv
